// ===== hw/rtl/knnli_pkg.sv =====
// knnli_pkg: slot, request and response word types and request codes
// for the sorted neighbor list insert unit. No dependencies.
`timescale 1ns / 1ps

package knnli_pkg;

	localparam int NB_W   = 10;
	localparam int DIST_W = 32;
	localparam int SLOT_W = 6;
	localparam int LEN_W  = 7;

	localparam logic [1:0] REQ_OFFER = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [LEN_W-1:0] LIST_LEN_RST = 7'd40;

	typedef struct packed {
		logic [NB_W-1:0]   nb;
		logic [DIST_W-1:0] dval;
		logic              mark;
	} slot_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [9:0]        node;
		logic [NB_W-1:0]   neighbor;
		logic [DIST_W-1:0] distance;
		logic [SLOT_W-1:0] slot;
		logic              new_mark;
		logic              clear_new;
	} req_word_t;

	typedef struct packed {
		logic              accepted;
		logic [SLOT_W-1:0] position;
		logic [NB_W-1:0]   read_neighbor;
		logic [DIST_W-1:0] read_distance;
		logic              read_new;
	} rsp_word_t;

endpackage

// ===== hw/rtl/knnli_stream_if.sv =====
// knnli_stream_if: valid/ready channel carrying one word of type word_t.
// Used with knnli_pkg word types.
`timescale 1ns / 1ps

interface knnli_stream_if #(parameter type word_t = logic) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/knn_list_sorted_insert_unit.sv =====
// knn_list_sorted_insert_unit: per-node sorted neighbor lists in a row memory.
// Result word registered in update, which stalls while a result is held.
// Idle takes one request, then runs row read, compare, encode and update/write.
// Reset: FSM and output valid cleared, list_len set to 40; list memory not reset.
// Depends on knnli_pkg, knnli_stream_if, knnli_row_mem.
`timescale 1ns / 1ps

module knn_list_sorted_insert_unit
	import knnli_pkg::*;
#(
	parameter int NODES    = 1024,
	parameter int MAX_LIST = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	knnli_stream_if.sink         cmd,
	knnli_stream_if.source       res,
	input  logic                 cfg_we,
	input  logic [LEN_W-1:0]     cfg_wdata
);

	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int SW = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
	localparam int KW = $clog2(MAX_LIST + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CMP  = 4'b0010,
		ST_ENC  = 4'b0100,
		ST_UPD  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [LEN_W-1:0]     list_len_q;
	req_word_t            req_q;
	rsp_word_t            rsp_q;
	logic                 rsp_valid_q;

	slot_t [MAX_LIST-1:0] row_s1;
	slot_t [MAX_LIST-1:0] shifted;
	slot_t [MAX_LIST-1:0] new_row;
	logic [MAX_LIST-1:0]  le_s2;
	logic [MAX_LIST-1:0]  lt_s2;
	logic [MAX_LIST-1:0]  nbeq_s2;
	logic                 far_s2;
	logic [MAX_LIST-1:0]  nbeq_s3;
	logic                 far_s3;
	logic [KW-1:0]        i_s3;
	logic [KW-1:0]        bp1_s3;

	logic [KW-1:0]        k_len;
	logic [SW-1:0]        last_idx;
	logic                 cmd_fire;
	logic                 finish;
	logic                 node_ok;
	logic                 slot_ok;
	logic [SW-1:0]        slot_idx;
	logic                 dup;
	logic [KW-1:0]        pos;
	logic                 done;
	logic                 mem_we;
	slot_t                ins;
	rsp_word_t            rsp_d;

	function automatic logic [KW-1:0] last_set(input logic [MAX_LIST-1:0] m);
		logic [KW-1:0] r;
		r = '0;
		for (int j = 0; j < MAX_LIST; j++) begin
			if (m[j]) begin
				r = KW'(j + 1);
			end
		end
		return r;
	endfunction

	// effective list length, clamped to 1..MAX_LIST
	always_comb begin
		if (list_len_q == '0) begin
			k_len = KW'(1);
		end else if (32'(list_len_q) > 32'(MAX_LIST)) begin
			k_len = KW'(MAX_LIST);
		end else begin
			k_len = KW'(list_len_q);
		end
	end

	assign last_idx  = SW'(k_len - KW'(1));
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign finish    = (state_q == ST_UPD) && (!rsp_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len_q <= LIST_LEN_RST;
		end else if (cfg_we) begin
			list_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_ENC;
				end
				ST_ENC: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			req_q <= cmd.data;
		end
	end

	knnli_row_mem #(
		.DEPTH (NODES),
		.SLOTS (MAX_LIST),
		.AW    (AW)
	) u_row_mem (
		.clk     (clk),
		.rd_en   (cmd_fire),
		.rd_addr (AW'(cmd.data.node)),
		.wr_en   (mem_we),
		.wr_addr (AW'(req_q.node)),
		.wr_data (new_row),
		.rd_data (row_s1)
	);

	// compare every slot against the offer
	always_ff @(posedge clk) begin
		if (state_q == ST_CMP) begin
			for (int j = 0; j < MAX_LIST; j++) begin
				le_s2[j]   <= (32'(j) < 32'(k_len)) && (row_s1[j].dval <= req_q.distance);
				lt_s2[j]   <= (32'(j) < 32'(k_len)) && (row_s1[j].dval < req_q.distance);
				nbeq_s2[j] <= (row_s1[j].nb == req_q.neighbor);
			end
			far_s2 <= (row_s1[last_idx].dval < req_q.distance);
		end
	end

	// i: one past the last slot not farther; bp1: one past the last closer slot
	always_ff @(posedge clk) begin
		if (state_q == ST_ENC) begin
			i_s3    <= last_set(le_s2);
			bp1_s3  <= last_set(lt_s2);
			nbeq_s3 <= nbeq_s2;
			far_s3  <= far_s2;
		end
	end

	assign node_ok  = (32'(req_q.node) < 32'(NODES));
	assign slot_ok  = (32'(req_q.slot) < 32'(k_len));
	assign slot_idx = SW'(req_q.slot);
	assign pos      = (i_s3 < k_len) ? i_s3 : KW'(k_len - KW'(1));

	// equal-distance run just below the insert point
	always_comb begin
		dup = 1'b0;
		for (int j = 0; j < MAX_LIST; j++) begin
			if (nbeq_s3[j] && (32'(j) >= 32'(bp1_s3)) && (32'(j) < 32'(i_s3))) begin
				dup = 1'b1;
			end
		end
	end

	always_comb begin
		shifted[0] = row_s1[0];
		for (int j = 1; j < MAX_LIST; j++) begin
			shifted[j] = row_s1[j - 1];
		end
	end

	assign ins = '{nb: req_q.neighbor, dval: req_q.distance, mark: 1'b1};

	always_comb begin
		new_row = row_s1;
		rsp_d   = '0;
		done    = 1'b0;
		mem_we  = 1'b0;
		if (node_ok) begin
			unique case (req_q.req_type)
				REQ_OFFER: begin
					if (!far_s3 && !dup) begin
						done = 1'b1;
						rsp_d.position = SLOT_W'(pos);
						for (int j = 0; j < MAX_LIST; j++) begin
							if (32'(j) == 32'(pos)) begin
								new_row[j] = ins;
							end else if ((32'(j) > 32'(pos)) && (32'(j) < 32'(k_len))) begin
								new_row[j] = shifted[j];
							end
						end
					end
				end
				REQ_WRITE: begin
					if (slot_ok) begin
						done = 1'b1;
						new_row[slot_idx] = '{nb: req_q.neighbor, dval: req_q.distance,
							mark: req_q.new_mark};
					end
				end
				REQ_READ: begin
					if (slot_ok) begin
						done = 1'b1;
						rsp_d.read_neighbor = row_s1[slot_idx].nb;
						rsp_d.read_distance = row_s1[slot_idx].dval;
						rsp_d.read_new      = row_s1[slot_idx].mark;
						if (req_q.clear_new) begin
							new_row[slot_idx].mark = 1'b0;
						end
					end
				end
				default: begin
					done = 1'b0;
				end
			endcase
		end
		rsp_d.accepted = done;
		mem_we = finish && done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (res.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign res.valid = rsp_valid_q;
	assign res.data  = rsp_q;

	a_fire_starts_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> (state_q == ST_CMP))
		else $error("request word did not start a row compare");

	a_rsp_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_UPD))
		else $error("response valid rose outside the update step");

	a_enc_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> ((i_s3 <= k_len) && (bp1_s3 <= i_s3)))
		else $error("insert point encode out of order");

	a_we_in_upd: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == ST_UPD) && node_ok))
		else $error("row write outside the update step or for a bad node");

endmodule

// ===== hw/rtl/knnli_row_mem.sv =====
// knnli_row_mem: one row of list slots per node, one write and one
// registered read per cycle. Depends on knnli_pkg.
`timescale 1ns / 1ps

module knnli_row_mem
	import knnli_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int SLOTS = 64,
	parameter int AW    = 10
) (
	input  logic                   clk,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  slot_t [SLOTS-1:0]      wr_data,
	output slot_t [SLOTS-1:0]      rd_data
);

	slot_t [SLOTS-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
